[sv/mwe_pkg.sv]
// ----------------------------------------------------------------------------
// mwe_pkg
// Shared types and constants for the microwire eeprom master: sequencer
// phases, command frame codes, opcodes, register indexes and reset values.
// ----------------------------------------------------------------------------
package mwe_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_WORD_MODE     = 3'd0;
   localparam logic [2:0] CSR_ADDRESS_BITS  = 3'd1;
   localparam logic [2:0] CSR_HALF_PERIOD   = 3'd2;
   localparam logic [2:0] CSR_POLL_READY    = 3'd3;
   localparam logic [2:0] CSR_READY_TIMEOUT = 3'd4;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 20;

   // configuration reset values
   localparam logic        WORD_MODE_RST     = 1'b1;
   localparam logic [3:0]  ADDRESS_BITS_RST  = 4'd6;
   localparam logic [7:0]  HALF_PERIOD_RST   = 8'd1;
   localparam logic        POLL_READY_RST    = 1'b1;
   localparam logic [19:0] READY_TIMEOUT_RST = 20'd600000;

   localparam int WAIT_COUNTER_BITS_DEF = 20;

   // address width limits
   localparam logic [3:0] ADDR_BITS_MIN = 4'd6;
   localparam logic [3:0] ADDR_BITS_MAX = 4'd8;

   // frame geometry: start bit + opcode + up to 8 address bits + up to 16 data bits
   localparam int CMD_BITS   = 11;
   localparam int FRAME_BITS = 27;
   localparam int COUNT_BITS = 5;

   // start bit followed by the two opcode bits
   localparam logic [2:0] CMD_READ  = 3'b110;
   localparam logic [2:0] CMD_WRITE = 3'b101;
   localparam logic [2:0] CMD_EXT   = 3'b100;

   typedef enum logic [1:0] {
      FR_READ  = 2'd0,
      FR_EWEN  = 2'd1,
      FR_WRITE = 2'd2,
      FR_EWDS  = 2'd3
   } frame_type;

   typedef enum logic [8:0] {
      PH_IDLE     = 9'b000000001,
      PH_SHIFT_LO = 9'b000000010,
      PH_SHIFT_HI = 9'b000000100,
      PH_READ_LO  = 9'b000001000,
      PH_READ_HI  = 9'b000010000,
      PH_DESEL    = 9'b000100000,
      PH_POLL     = 9'b001000000,
      PH_FIXED    = 9'b010000000,
      PH_GAP      = 9'b100000000
   } phase_type;

endpackage

[sv/mwe_frame_gen.sv]
// ----------------------------------------------------------------------------
// mwe_frame_gen
// Builds one command frame: start bit, opcode, address and, for a write,
// the data word, right aligned, with the number of bits to send.
// ----------------------------------------------------------------------------
module mwe_frame_gen (
   input  mwe_pkg::frame_type                    frame,
   input  logic                                  word_mode,
   input  logic [3:0]                            address_bits,
   input  logic [7:0]                            address,
   input  logic [15:0]                           write_data,
   output logic [mwe_pkg::FRAME_BITS-1:0]        shift_word,
   output logic [mwe_pkg::COUNT_BITS-1:0]        bit_count
);
   import mwe_pkg::*;

   logic [3:0]          addr_w;
   logic [7:0]          addr_mask;
   logic [7:0]          addr_field;
   logic [2:0]          cmd;
   logic [CMD_BITS-1:0] cmd_word;
   logic [15:0]         data_field;

   // out-of-range address widths clamp to 6..8
   always_comb begin
      if (address_bits < ADDR_BITS_MIN) begin
         addr_w = ADDR_BITS_MIN;
      end else if (address_bits > ADDR_BITS_MAX) begin
         addr_w = ADDR_BITS_MAX;
      end else begin
         addr_w = address_bits;
      end
   end

   assign addr_mask  = 8'((9'd1 << addr_w) - 9'd1);
   assign data_field = word_mode ? write_data : {8'd0, write_data[7:0]};

   always_comb begin
      unique case (frame)
         FR_READ: begin
            cmd        = CMD_READ;
            addr_field = address & addr_mask;
         end
         FR_WRITE: begin
            cmd        = CMD_WRITE;
            addr_field = address & addr_mask;
         end
         FR_EWEN: begin
            // opcode 00 then 11 in the two top address bits
            cmd        = CMD_EXT;
            addr_field = 8'(8'd3 << (addr_w - 4'd2));
         end
         default: begin
            cmd        = CMD_EXT;
            addr_field = 8'd0;
         end
      endcase
   end

   assign cmd_word = (CMD_BITS'(cmd) << addr_w) | CMD_BITS'(addr_field);

   always_comb begin
      if (frame == FR_WRITE) begin
         if (word_mode) begin
            shift_word = (FRAME_BITS'(cmd_word) << 16) | FRAME_BITS'(data_field);
            bit_count  = COUNT_BITS'(5'd19 + {1'b0, addr_w});
         end else begin
            shift_word = (FRAME_BITS'(cmd_word) << 8) | FRAME_BITS'(data_field);
            bit_count  = COUNT_BITS'(5'd11 + {1'b0, addr_w});
         end
      end else begin
         shift_word = FRAME_BITS'(cmd_word);
         bit_count  = COUNT_BITS'(5'd3 + {1'b0, addr_w});
      end
   end

endmodule

[sv/microwire_eeprom_master_unit.sv]
// ----------------------------------------------------------------------------
// microwire_eeprom_master_unit
// Microwire serial eeprom master: read, or write wrapped in ewen/ewds, one
// sequencer tick per accepted word, with ready polling or fixed wait.
// ----------------------------------------------------------------------------
// latency: the result word for a request appears on the cycle after it is taken
// throughput: one request word per cycle; the only stall is a held result
// the sequencer state and the result register update together in that cycle
// synchronous active-high reset: sequencer idle, outputs zero, registers at
// their defaults (16-bit words, 6 address bits, half period 1, poll, 600000)
module microwire_eeprom_master_unit #(
   parameter int WAIT_COUNTER_BITS = mwe_pkg::WAIT_COUNTER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mwe_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mwe_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_start_req,
   input  logic                                req_action,
   input  logic [7:0]                          req_address,
   input  logic [15:0]                         req_write_data,
   input  logic                                req_eeprom_out_bit,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_chip_select,
   output logic                                rsp_shift_clock,
   output logic                                rsp_eeprom_in_bit,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [15:0]                         rsp_read_value,
   output logic                                rsp_timed_out
);
   import mwe_pkg::*;

   localparam int WCB   = WAIT_COUNTER_BITS;
   localparam int CMP_W = (WCB > 20) ? WCB : 20;
   localparam logic [WCB-1:0] WAIT_MAX = {WCB{1'b1}};

   // configuration
   logic        word_mode_ff,     word_mode_in;
   logic [3:0]  address_bits_ff,  address_bits_in;
   logic [7:0]  half_period_ff,   half_period_in;
   logic        poll_ready_ff,    poll_ready_in;
   logic [19:0] ready_timeout_ff, ready_timeout_in;

   // sequencer
   phase_type                phase_ff,     phase_in;
   frame_type                frame_ff,     frame_in;
   logic [COUNT_BITS-1:0]    bit_count_ff, bit_count_in;
   logic [FRAME_BITS-1:0]    shift_ff,     shift_in;
   logic [7:0]               divider_ff,   divider_in;
   logic [WCB-1:0]           wait_ff,      wait_in;
   logic [15:0]              read_shift_ff, read_shift_in;
   logic [7:0]               held_addr_ff, held_addr_in;
   logic [15:0]              held_data_ff, held_data_in;
   logic [15:0]              last_read_ff, last_read_in;
   logic                     timeout_ff,   timeout_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        cs_ff, cs_in;
   logic        sk_ff, sk_in;
   logic        di_ff, di_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   logic                  in_acc;
   frame_type             frame_sel;
   logic [7:0]            frame_addr;
   logic [15:0]           frame_data;
   logic [FRAME_BITS-1:0] frame_shift;
   logic [COUNT_BITS-1:0] frame_bits;
   logic [7:0]            hp_eff;
   logic                  half_done;
   logic [7:0]            divider_adv;
   logic [COUNT_BITS-1:0] bit_dec;
   logic [15:0]           read_next;
   logic [WCB-1:0]        wait_inc;
   logic [CMP_W-1:0]      wait_lim;
   logic                  wait_end;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign in_acc    = req_valid & ~req_stall;

   // ---------------------------------------------------------------- config
   always_comb begin
      word_mode_in     = word_mode_ff;
      address_bits_in  = address_bits_ff;
      half_period_in   = half_period_ff;
      poll_ready_in    = poll_ready_ff;
      ready_timeout_in = ready_timeout_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_WORD_MODE:     word_mode_in     = csr_wdata[0];
            CSR_ADDRESS_BITS:  address_bits_in  = csr_wdata[3:0];
            CSR_HALF_PERIOD:   half_period_in   = csr_wdata[7:0];
            CSR_POLL_READY:    poll_ready_in    = csr_wdata[0];
            CSR_READY_TIMEOUT: ready_timeout_in = csr_wdata[19:0];
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- frames
   always_comb begin
      if (phase_ff == PH_IDLE) begin
         frame_sel  = req_action ? FR_EWEN : FR_READ;
         frame_addr = req_address;
         frame_data = req_write_data;
      end else if (phase_ff == PH_DESEL) begin
         frame_sel  = FR_WRITE;
         frame_addr = held_addr_ff;
         frame_data = held_data_ff;
      end else begin
         frame_sel  = FR_EWDS;
         frame_addr = held_addr_ff;
         frame_data = held_data_ff;
      end
   end

   mwe_frame_gen u_frame_gen (
      .frame        (frame_sel),
      .word_mode    (word_mode_ff),
      .address_bits (address_bits_ff),
      .address      (frame_addr),
      .write_data   (frame_data),
      .shift_word   (frame_shift),
      .bit_count    (frame_bits)
   );

   // ---------------------------------------------------------------- timing
   assign hp_eff      = (half_period_ff == 8'd0) ? 8'd1 : half_period_ff;
   assign half_done   = ({1'b0, divider_ff} + 9'd1) >= {1'b0, hp_eff};
   assign divider_adv = half_done ? 8'd0 : 8'(divider_ff + 8'd1);
   assign bit_dec     = (bit_count_ff != '0) ? COUNT_BITS'(bit_count_ff - 1'b1) : '0;
   assign read_next   = {read_shift_ff[14:0], req_eeprom_out_bit};

   // saturating wait counter against the clipped timeout
   assign wait_inc = (wait_ff != WAIT_MAX) ? WCB'(wait_ff + 1'b1) : wait_ff;
   assign wait_lim = (CMP_W'(ready_timeout_ff) > CMP_W'(WAIT_MAX)) ?
                     CMP_W'(WAIT_MAX) : CMP_W'(ready_timeout_ff);
   assign wait_end = CMP_W'(wait_inc) >= wait_lim;

   // ---------------------------------------------------------------- next state
   always_comb begin
      phase_in      = phase_ff;
      frame_in      = frame_ff;
      bit_count_in  = bit_count_ff;
      shift_in      = shift_ff;
      divider_in    = divider_ff;
      wait_in       = wait_ff;
      read_shift_in = read_shift_ff;
      held_addr_in  = held_addr_ff;
      held_data_in  = held_data_ff;
      last_read_in  = last_read_ff;
      timeout_in    = timeout_ff;
      done_in       = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_start_req) begin
               held_addr_in = req_address;
               held_data_in = req_write_data;
               timeout_in   = 1'b0;
               wait_in      = '0;
               frame_in     = frame_sel;
               shift_in     = frame_shift;
               bit_count_in = frame_bits;
               divider_in   = 8'd0;
               phase_in     = PH_SHIFT_LO;
            end
         end
         PH_SHIFT_LO: begin
            divider_in = divider_adv;
            if (half_done) begin
               phase_in = PH_SHIFT_HI;
            end
         end
         PH_SHIFT_HI: begin
            divider_in = divider_adv;
            if (half_done) begin
               if (bit_dec != '0) begin
                  bit_count_in = bit_dec;
                  phase_in     = PH_SHIFT_LO;
               end else if (frame_ff == FR_READ) begin
                  bit_count_in  = word_mode_ff ? COUNT_BITS'(16) : COUNT_BITS'(8);
                  read_shift_in = 16'd0;
                  phase_in      = PH_READ_LO;
               end else begin
                  bit_count_in = bit_dec;
                  phase_in     = PH_DESEL;
               end
            end
         end
         PH_READ_LO: begin
            divider_in = divider_adv;
            if (half_done) begin
               phase_in = PH_READ_HI;
            end
         end
         PH_READ_HI: begin
            divider_in = divider_adv;
            if (half_done) begin
               read_shift_in = read_next;
               bit_count_in  = bit_dec;
               if (bit_dec == '0) begin
                  last_read_in = read_next;
                  phase_in     = PH_DESEL;
               end else begin
                  phase_in = PH_READ_LO;
               end
            end
         end
         PH_DESEL: begin
            divider_in = divider_adv;
            if (half_done) begin
               if (frame_ff == FR_EWEN) begin
                  frame_in     = FR_WRITE;
                  shift_in     = frame_shift;
                  bit_count_in = frame_bits;
                  divider_in   = 8'd0;
                  phase_in     = PH_SHIFT_LO;
               end else if (frame_ff == FR_WRITE) begin
                  wait_in  = '0;
                  phase_in = poll_ready_ff ? PH_POLL : PH_FIXED;
               end else begin
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
            end
         end
         PH_POLL: begin
            if (req_eeprom_out_bit) begin
               phase_in   = PH_GAP;
               divider_in = 8'd0;
            end else begin
               wait_in = wait_inc;
               if (wait_end) begin
                  timeout_in = 1'b1;
                  phase_in   = PH_GAP;
                  divider_in = 8'd0;
               end
            end
         end
         PH_FIXED: begin
            wait_in = wait_inc;
            if (wait_end) begin
               phase_in   = PH_GAP;
               divider_in = 8'd0;
            end
         end
         PH_GAP: begin
            divider_in = divider_adv;
            if (half_done) begin
               frame_in     = FR_EWDS;
               shift_in     = frame_shift;
               bit_count_in = frame_bits;
               divider_in   = 8'd0;
               phase_in     = PH_SHIFT_LO;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- pin drives
   always_comb begin
      cs_in = 1'b0;
      sk_in = 1'b0;
      di_in = 1'b0;
      if ((phase_in == PH_SHIFT_LO) || (phase_in == PH_SHIFT_HI)) begin
         cs_in = 1'b1;
         sk_in = (phase_in == PH_SHIFT_HI);
         if ((bit_count_in != '0) && (bit_count_in <= COUNT_BITS'(FRAME_BITS))) begin
            di_in = shift_in[COUNT_BITS'(bit_count_in - 1'b1)];
         end
      end else if ((phase_in == PH_READ_LO) || (phase_in == PH_READ_HI)) begin
         cs_in = 1'b1;
         sk_in = (phase_in == PH_READ_HI);
      end else if (phase_in == PH_POLL) begin
         cs_in = 1'b1;
      end
   end

   assign busy_in      = (phase_in != PH_IDLE);
   assign rsp_valid_in = in_acc | req_stall;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         word_mode_ff     <= WORD_MODE_RST;
         address_bits_ff  <= ADDRESS_BITS_RST;
         half_period_ff   <= HALF_PERIOD_RST;
         poll_ready_ff    <= POLL_READY_RST;
         ready_timeout_ff <= READY_TIMEOUT_RST;
      end else begin
         word_mode_ff     <= word_mode_in;
         address_bits_ff  <= address_bits_in;
         half_period_ff   <= half_period_in;
         poll_ready_ff    <= poll_ready_in;
         ready_timeout_ff <= ready_timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         last_read_ff <= 16'd0;
         timeout_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (in_acc) begin
            phase_ff     <= phase_in;
            last_read_ff <= last_read_in;
            timeout_ff   <= timeout_in;
         end
      end
   end

   // datapath and result payload advance only on an accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff      <= FR_READ;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         divider_ff    <= 8'd0;
         wait_ff       <= '0;
         read_shift_ff <= 16'd0;
         held_addr_ff  <= 8'd0;
         held_data_ff  <= 16'd0;
         cs_ff         <= 1'b0;
         sk_ff         <= 1'b0;
         di_ff         <= 1'b0;
         busy_ff       <= 1'b0;
         done_ff       <= 1'b0;
      end else if (in_acc) begin
         frame_ff      <= frame_in;
         bit_count_ff  <= bit_count_in;
         shift_ff      <= shift_in;
         divider_ff    <= divider_in;
         wait_ff       <= wait_in;
         read_shift_ff <= read_shift_in;
         held_addr_ff  <= held_addr_in;
         held_data_ff  <= held_data_in;
         cs_ff         <= cs_in;
         sk_ff         <= sk_in;
         di_ff         <= di_in;
         busy_ff       <= busy_in;
         done_ff       <= done_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_chip_select   = cs_ff;
   assign rsp_shift_clock   = sk_ff;
   assign rsp_eeprom_in_bit = di_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_done_res      = done_ff;
   assign rsp_read_value    = last_read_ff;
   assign rsp_timed_out     = timeout_ff;

endmodule
